### design/dcks_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcks_pkg;

  // Position in the fixed certificate schema.
  typedef enum logic [3:0] {
    STG_OUTER   = 4'd0,
    STG_TBS     = 4'd1,
    STG_SKIP    = 4'd2,
    STG_KEYSEQ  = 4'd3,
    STG_ALGID   = 4'd4,
    STG_KEYBITS = 4'd5,
    STG_TBSREST = 4'd6,
    STG_SIGALG  = 4'd7,
    STG_SIGBITS = 4'd8,
    STG_SIGSEQ  = 4'd9,
    STG_INT1    = 4'd10,
    STG_INT2    = 4'd11
  } stage_t;

  // Position inside one element header.
  typedef enum logic [2:0] {
    PH_TAG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_LONG = 3'd2,
    PH_ZCHK = 3'd3,
    PH_BODY = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_WRONG_TAG = 3'd1,
    STS_BAD_LEN   = 3'd2,
    STS_TRUNC     = 3'd3,
    STS_SIG_OVF   = 3'd4,
    STS_KEY_OVF   = 3'd5
  } status_t;

  localparam int unsigned KEY_CAP_W     = 11;
  localparam logic [KEY_CAP_W-1:0] KEY_CAP_RESET = 11'd65;

  localparam logic [7:0] TAG_SEQUENCE   = 8'h30;
  localparam logic [7:0] TAG_BIT_STRING = 8'h03;
  localparam logic [7:0] TAG_INTEGER    = 8'h02;
  localparam logic [6:0] MAX_LEN_BYTES  = 7'd4;
  localparam logic [2:0] SKIP_ELEMS     = 3'd6;

  typedef struct packed {
    stage_t               stage;
    phase_t               phase;
    logic [2:0]           len_left;
    logic [31:0]          elem_left;
    logic [31:0]          tbs_left;
    logic [2:0]           skip_cnt;
    logic [KEY_CAP_W-1:0] key_cnt;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    stage:     STG_OUTER,
    phase:     PH_TAG,
    len_left:  3'd0,
    elem_left: 32'd0,
    tbs_left:  32'd0,
    skip_cnt:  3'd0,
    key_cnt:   '0
  };

  // Per-byte result flags.
  typedef struct packed {
    logic    tbs;
    logic    key;
    logic    sig;
    logic    done;
    status_t status;
  } res_t;

endpackage

`default_nettype wire

### design/dcks_step.sv
`timescale 1ns / 1ps
`default_nettype none

module dcks_step #(
  parameter int unsigned SIG_BYTES = 64,
  parameter int unsigned SIG_CNT_W = 7
) (
  input  wire logic [7:0]                        byte_i,
  input  wire logic                              last_i,
  input  wire logic [dcks_pkg::KEY_CAP_W-1:0]    key_cap_i,
  input  wire dcks_pkg::parse_state_t            st_i,
  input  wire logic [SIG_CNT_W-1:0]              sig_cnt_i,
  input  wire logic                              fin_i,
  output dcks_pkg::parse_state_t                 st_o,
  output logic [SIG_CNT_W-1:0]                   sig_cnt_o,
  output logic                                   fin_o,
  output dcks_pkg::res_t                         res_o
);

  typedef struct packed {
    dcks_pkg::parse_state_t st;
    logic                   done;
  } walk_t;

  function automatic logic [7:0] expected_tag(input dcks_pkg::stage_t stg);
    logic [7:0] t;
    if (stg == dcks_pkg::STG_KEYBITS || stg == dcks_pkg::STG_SIGBITS) begin
      t = dcks_pkg::TAG_BIT_STRING;
    end else if (stg == dcks_pkg::STG_INT1 || stg == dcks_pkg::STG_INT2) begin
      t = dcks_pkg::TAG_INTEGER;
    end else begin
      t = dcks_pkg::TAG_SEQUENCE;
    end
    return t;
  endfunction

  function automatic walk_t complete_elem(input dcks_pkg::parse_state_t s);
    walk_t w;
    w.st = s;
    w.done = 1'b0;
    w.st.phase = dcks_pkg::PH_TAG;
    unique case (s.stage)
      dcks_pkg::STG_SKIP: begin
        w.st.skip_cnt = s.skip_cnt + 3'd1;
        if (w.st.skip_cnt >= dcks_pkg::SKIP_ELEMS) begin
          w.st.stage = dcks_pkg::STG_KEYSEQ;
        end
      end
      dcks_pkg::STG_ALGID:  w.st.stage = dcks_pkg::STG_KEYBITS;
      dcks_pkg::STG_KEYBITS: begin
        w.st.stage = (s.tbs_left == 32'd0) ? dcks_pkg::STG_SIGALG : dcks_pkg::STG_TBSREST;
      end
      dcks_pkg::STG_SIGALG: w.st.stage = dcks_pkg::STG_SIGBITS;
      dcks_pkg::STG_INT1:   w.st.stage = dcks_pkg::STG_INT2;
      default:              w.done = 1'b1;
    endcase
    return w;
  endfunction

  // Containers are entered directly; their content is walked as headers.
  function automatic walk_t enter_body(input dcks_pkg::parse_state_t s);
    walk_t w;
    w.st = s;
    w.done = 1'b0;
    unique case (s.stage)
      dcks_pkg::STG_OUTER: begin
        w.st.stage = dcks_pkg::STG_TBS;
        w.st.phase = dcks_pkg::PH_TAG;
      end
      dcks_pkg::STG_TBS: begin
        w.st.stage = dcks_pkg::STG_SKIP;
        w.st.phase = dcks_pkg::PH_TAG;
      end
      dcks_pkg::STG_KEYSEQ: begin
        w.st.stage = dcks_pkg::STG_ALGID;
        w.st.phase = dcks_pkg::PH_TAG;
      end
      dcks_pkg::STG_SIGBITS: begin
        w.st.stage = dcks_pkg::STG_SIGSEQ;
        w.st.phase = dcks_pkg::PH_TAG;
      end
      dcks_pkg::STG_SIGSEQ: begin
        w.st.stage = dcks_pkg::STG_INT1;
        w.st.phase = dcks_pkg::PH_TAG;
      end
      default: begin
        if (s.elem_left == 32'd0) begin
          w = complete_elem(s);
        end else begin
          w.st.phase = dcks_pkg::PH_BODY;
        end
      end
    endcase
    return w;
  endfunction

  function automatic walk_t header_done(input dcks_pkg::parse_state_t s);
    walk_t                  w;
    dcks_pkg::parse_state_t t;
    t = s;
    if (s.stage == dcks_pkg::STG_TBS) begin
      t.tbs_left = s.elem_left;
    end
    if (s.stage != dcks_pkg::STG_SKIP && s.elem_left != 32'd0) begin
      w.st = t;
      w.st.phase = dcks_pkg::PH_ZCHK;
      w.done = 1'b0;
    end else begin
      w = enter_body(t);
    end
    return w;
  endfunction

  always_comb begin
    dcks_pkg::parse_state_t s;
    walk_t                  w;
    logic [SIG_CNT_W-1:0]   sig;
    logic                   fin;
    logic                   done;
    dcks_pkg::status_t      stat;
    logic                   rt;
    logic                   rk;
    logic                   rs;
    logic                   region;
    logic                   is_int;
    logic [6:0]             n;

    s = st_i;
    sig = sig_cnt_i;
    fin = fin_i;
    done = 1'b0;
    stat = dcks_pkg::STS_OK;
    rt = 1'b0;
    rk = 1'b0;
    rs = 1'b0;
    n = byte_i[6:0];
    w.st = st_i;
    w.done = 1'b0;
    region = (st_i.stage == dcks_pkg::STG_TBS && st_i.phase == dcks_pkg::PH_ZCHK) ||
             (st_i.stage >= dcks_pkg::STG_SKIP && st_i.stage <= dcks_pkg::STG_TBSREST);
    is_int = 1'b0;

    if (fin_i) begin
      // Drain the rest of a certificate that ended early.
      if (last_i) begin
        s = dcks_pkg::PARSE_RESET;
        sig = '0;
        fin = 1'b0;
      end
    end else begin
      if (region) begin
        if (s.tbs_left == 32'd0) begin
          done = 1'b1;
          stat = dcks_pkg::STS_BAD_LEN;
        end else begin
          s.tbs_left = s.tbs_left - 32'd1;
          rt = 1'b1;
        end
      end else if (s.stage == dcks_pkg::STG_TBS) begin
        rt = 1'b1;
      end

      if (!done) begin
        if (s.stage == dcks_pkg::STG_TBSREST) begin
          if (s.tbs_left == 32'd0) begin
            s.stage = dcks_pkg::STG_SIGALG;
          end
        end else begin
          // A nonzero byte where a leading zero may stand belongs to the body, or to the
          // first inner element of a container, so it is handled again in the new phase.
          if (s.phase == dcks_pkg::PH_ZCHK && byte_i != 8'd0) begin
            w = enter_body(s);
            s = w.st;
          end
          is_int = (s.stage == dcks_pkg::STG_INT1 || s.stage == dcks_pkg::STG_INT2);
          unique case (s.phase)
            dcks_pkg::PH_TAG: begin
              if (s.stage != dcks_pkg::STG_SKIP && byte_i != expected_tag(s.stage)) begin
                done = 1'b1;
                stat = dcks_pkg::STS_WRONG_TAG;
              end else begin
                s.phase = dcks_pkg::PH_LEN;
              end
            end
            dcks_pkg::PH_LEN: begin
              if (!byte_i[7]) begin
                s.elem_left = {24'd0, byte_i};
                w = header_done(s);
                s = w.st;
                done = w.done;
              end else if (n == 7'd0 || n > dcks_pkg::MAX_LEN_BYTES) begin
                done = 1'b1;
                stat = dcks_pkg::STS_BAD_LEN;
              end else begin
                s.len_left = n[2:0];
                s.elem_left = 32'd0;
                s.phase = dcks_pkg::PH_LONG;
              end
            end
            dcks_pkg::PH_LONG: begin
              s.elem_left = {s.elem_left[23:0], byte_i};
              s.len_left = s.len_left - 3'd1;
              if (s.len_left == 3'd0) begin
                w = header_done(s);
                s = w.st;
                done = w.done;
              end
            end
            dcks_pkg::PH_ZCHK: begin
              // Only a zero byte reaches here.
              s.elem_left = s.elem_left - 32'd1;
              w = enter_body(s);
              s = w.st;
              done = w.done;
            end
            default: begin
              if (s.stage == dcks_pkg::STG_KEYBITS && s.key_cnt >= key_cap_i) begin
                done = 1'b1;
                stat = dcks_pkg::STS_KEY_OVF;
              end else if (is_int && sig >= SIG_CNT_W'(SIG_BYTES)) begin
                done = 1'b1;
                stat = dcks_pkg::STS_SIG_OVF;
              end else begin
                if (s.stage == dcks_pkg::STG_KEYBITS) begin
                  s.key_cnt = s.key_cnt + dcks_pkg::KEY_CAP_W'(1);
                  rk = 1'b1;
                end else if (is_int) begin
                  sig = sig + SIG_CNT_W'(1);
                  rs = 1'b1;
                end
                s.elem_left = s.elem_left - 32'd1;
                if (s.elem_left == 32'd0) begin
                  w = complete_elem(s);
                  s = w.st;
                  done = w.done;
                end
              end
            end
          endcase
        end
      end

      if (done && stat != dcks_pkg::STS_OK) begin
        rt = 1'b0;
        rk = 1'b0;
        rs = 1'b0;
      end
      if (!done && last_i) begin
        done = 1'b1;
        stat = dcks_pkg::STS_TRUNC;
      end
      if (done) begin
        if (last_i) begin
          s = dcks_pkg::PARSE_RESET;
          sig = '0;
          fin = 1'b0;
        end else begin
          fin = 1'b1;
        end
      end
    end

    st_o = s;
    sig_cnt_o = sig;
    fin_o = fin;
    res_o.tbs = rt;
    res_o.key = rk;
    res_o.sig = rs;
    res_o.done = done;
    res_o.status = stat;
  end

endmodule

`default_nettype wire

### design/der_cert_key_sig_extractor.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Handshake           | Payload
// in      | in  | in_valid / in_stall | in_byte, in_last_byte
// out     | out | out_valid/out_stall | out_byte, out_in_tbs/key/sig, out_done_res, out_status
// cfg     | in  | cfg_valid/cfg_ready | cfg_key_capacity
//
// One byte per cycle sustained while out_stall is low. The parse step runs between
// the input register and the result register, so a result is offered on the output
// once its byte has passed through both registers.
// Reset is synchronous: it clears the parser and sets key_capacity to 65.
// A stalled result holds; the input stalls only when both registers are full
// and the result cannot leave. cfg_ready is always high.
module der_cert_key_sig_extractor #(
  parameter int unsigned SIG_BYTES = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_byte,
  input  wire logic                            in_last_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           out_byte,
  output logic                                 out_in_tbs,
  output logic                                 out_in_key,
  output logic                                 out_in_sig,
  output logic                                 out_done_res,
  output logic [2:0]                           out_status,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dcks_pkg::KEY_CAP_W-1:0]  cfg_key_capacity
);

  localparam int unsigned SIG_CNT_W = $clog2(SIG_BYTES + 1);

  logic                               s1_vld_r;
  logic [7:0]                         s1_byte_r;
  logic                               s1_last_r;
  logic                               adv;

  dcks_pkg::parse_state_t             st_r;
  dcks_pkg::parse_state_t             st_nxt;
  logic [SIG_CNT_W-1:0]               sig_cnt_r;
  logic [SIG_CNT_W-1:0]               sig_cnt_nxt;
  logic                               fin_r;
  logic                               fin_nxt;
  dcks_pkg::res_t                     res;
  logic [dcks_pkg::KEY_CAP_W-1:0]     key_cap_r;

  logic                               out_valid_r;
  logic [7:0]                         out_byte_r;
  dcks_pkg::res_t                     out_res_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = s1_vld_r && !adv;
  assign cfg_ready = 1'b1;

  dcks_step #(
    .SIG_BYTES (SIG_BYTES),
    .SIG_CNT_W (SIG_CNT_W)
  ) u_step (
    .byte_i    (s1_byte_r),
    .last_i    (s1_last_r),
    .key_cap_i (key_cap_r),
    .st_i      (st_r),
    .sig_cnt_i (sig_cnt_r),
    .fin_i     (fin_r),
    .st_o      (st_nxt),
    .sig_cnt_o (sig_cnt_nxt),
    .fin_o     (fin_nxt),
    .res_o     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_cap_r <= dcks_pkg::KEY_CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      key_cap_r <= cfg_key_capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_vld_r <= 1'b1;
    end else if (adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Parser state moves only when a byte transfers into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= dcks_pkg::PARSE_RESET;
      sig_cnt_r   <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_vld_r;
      if (s1_vld_r) begin
        st_r      <= st_nxt;
        sig_cnt_r <= sig_cnt_nxt;
        fin_r     <= fin_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_vld_r) begin
      out_byte_r <= s1_byte_r;
      out_res_r  <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_in_tbs   = out_res_r.tbs;
  assign out_in_key   = out_res_r.key;
  assign out_in_sig   = out_res_r.sig;
  assign out_done_res = out_res_r.done;
  assign out_status   = out_res_r.status;

  a_status_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != dcks_pkg::STS_OK) |-> out_res_r.done)
    else $error("nonzero status without done");

  a_fail_clears_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != dcks_pkg::STS_OK &&
     out_res_r.status != dcks_pkg::STS_TRUNC)
    |-> (!out_res_r.tbs && !out_res_r.key && !out_res_r.sig))
    else $error("failing byte carries region flags");

  a_key_inside_tbs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.key) |-> (out_res_r.tbs && !out_res_r.sig))
    else $error("key byte outside the signed section");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && out_valid_r))
    else $error("input stalled with a free register");

endmodule

`default_nettype wire
